// ===== hw/rtl/rrts_pkg.sv =====
// Shared types and constants for the round-robin task scheduler.
// Holds the request/response payloads, task marks and link-memory port bundles.
// No dependencies.
package rrts_pkg;

   localparam int NUM_TASKS = 16;
   localparam int TASK_W    = 4;
   localparam int SIZE_W    = 5;
   localparam int QUANT_W   = 8;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 8;

   // Task marks
   typedef enum logic [1:0] {
      MARK_FREE    = 2'd0,
      MARK_READY   = 2'd1,
      MARK_BLOCKED = 2'd2,
      MARK_RUN     = 2'd3
   } mark_type;

   // Request modes
   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_MOVE = 1'b1;

   // Move destinations (anything else means blocked)
   localparam logic [1:0] DEST_READY = 2'd0;
   localparam logic [1:0] DEST_FREE  = 2'd1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE    = 1'b1;

   typedef struct packed {
      logic              mode;
      logic [TASK_W-1:0] task_id;
      logic [1:0]        destination;
   } req_type;

   typedef struct packed {
      logic [TASK_W-1:0] running_task;
      logic              switched;
      logic [SIZE_W-1:0] ready_count;
      logic              status;
   } rsp_type;

   typedef struct packed {
      logic [QUANT_W-1:0] quantum_length;
      logic [TASK_W-1:0]  idle_task_id;
   } cfg_type;

   typedef struct packed {
      logic              re;
      logic [TASK_W-1:0] next_addr;
      logic [TASK_W-1:0] prev_addr;
   } link_rd_type;

   typedef struct packed {
      logic              next_we;
      logic [TASK_W-1:0] next_addr;
      logic [TASK_W-1:0] next_data;
      logic              prev_we;
      logic [TASK_W-1:0] prev_addr;
      logic [TASK_W-1:0] prev_data;
   } link_wr_type;

   typedef struct packed {
      logic busy;
      logic done;
   } eng_status_type;

endpackage

// ===== hw/rtl/round_robin_task_scheduler_core.sv =====
// Round-robin task scheduler core. An accepted request executes and loads the response
// register when that is free; a move to ready of a task in the queue interior passes an
// append state first. A new request is taken only once the sequencer is idle, after
// the link memory read and its write-back. Synchronous active-high reset: task 1 running,
// all others free, queue empty, quantum 0, quantum_length 10, idle task 0.
module round_robin_task_scheduler_core import rrts_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   // register write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [QUANT_W-1:0] quantum_length_ff;
   logic [TASK_W-1:0]  idle_task_ff;
   cfg_type            cfg;

   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;
   logic               rsp_free;
   logic               start;

   link_rd_type        link_rd;
   link_wr_type        link_wr;
   logic [TASK_W-1:0]  next_rd;
   logic [TASK_W-1:0]  prev_rd;
   eng_status_type     stat;
   rsp_type            result;

   // Registers are always writable; writes land only while idle by contract
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_length_ff <= QUANT_W'(10);
         idle_task_ff      <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_QUANTUM: quantum_length_ff <= csr_data[QUANT_W-1:0];
            CSR_IDLE:    idle_task_ff      <= csr_data[TASK_W-1:0];
            default:     ;
         endcase
      end
   end

   assign cfg.quantum_length = quantum_length_ff;
   assign cfg.idle_task_id   = idle_task_ff;

   // Take one request at a time; hold off while the sequencer is busy
   assign req_stall = stat.busy;
   assign start     = req_valid && !req_stall;

   // Output register may be refilled when empty or being drained this cycle
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   rrts_link_mem u_link_mem (
      .clock   (clock),
      .rd      (link_rd),
      .wr      (link_wr),
      .next_rd (next_rd),
      .prev_rd (prev_rd)
   );

   rrts_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req      (req_data),
      .cfg      (cfg),
      .rsp_free (rsp_free),
      .next_rd  (next_rd),
      .prev_rd  (prev_rd),
      .link_rd  (link_rd),
      .link_wr  (link_wr),
      .stat     (stat),
      .result   (result)
   );

   // Response register: load on completion, drop once taken, hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stat.done) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (stat.done) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/rrts_link_mem.sv =====
// Ready-queue link storage: next and prev pointer memories.
// One write and one registered read per memory each cycle; uses rrts_pkg.
module rrts_link_mem import rrts_pkg::*; (
   input  logic              clock,
   input  link_rd_type       rd,
   input  link_wr_type       wr,
   output logic [TASK_W-1:0] next_rd,
   output logic [TASK_W-1:0] prev_rd
);

   logic [TASK_W-1:0] next_mem [NUM_TASKS];
   logic [TASK_W-1:0] prev_mem [NUM_TASKS];
   logic [TASK_W-1:0] next_rd_ff;
   logic [TASK_W-1:0] prev_rd_ff;

   always_ff @(posedge clock) begin
      if (wr.next_we) begin
         next_mem[wr.next_addr] <= wr.next_data;
      end
      if (wr.prev_we) begin
         prev_mem[wr.prev_addr] <= wr.prev_data;
      end
      if (rd.re) begin
         next_rd_ff <= next_mem[rd.next_addr];
         prev_rd_ff <= prev_mem[rd.prev_addr];
      end
   end

   assign next_rd = next_rd_ff;
   assign prev_rd = prev_rd_ff;

endmodule

// ===== hw/rtl/rrts_engine.sv =====
// Scheduler sequencer: queue head/tail/count, running task, quantum and task marks.
// Reads the link memory on accept, modifies and writes back; uses rrts_pkg.
module rrts_engine import rrts_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  req_type           req,
   input  cfg_type           cfg,
   input  logic              rsp_free,
   input  logic [TASK_W-1:0] next_rd,
   input  logic [TASK_W-1:0] prev_rd,
   output link_rd_type       link_rd,
   output link_wr_type       link_wr,
   output eng_status_type    stat,
   output rsp_type           result
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_APPEND
   } state_type;

   state_type          state_ff,   state_in;
   req_type            req_ff,     req_in;
   logic [TASK_W-1:0]  head_ff,    head_in;
   logic [TASK_W-1:0]  tail_ff,    tail_in;
   logic [SIZE_W-1:0]  size_ff,    size_in;
   logic [TASK_W-1:0]  running_ff, running_in;
   logic [QUANT_W-1:0] quantum_ff, quantum_in;
   mark_type           mark_ff [NUM_TASKS];
   mark_type           mark_in [NUM_TASKS];
   logic               done;
   logic               switched;
   logic               status;

   always_comb begin
      logic [QUANT_W-1:0] q_dec;
      logic               append_run;
      logic               run_valid;
      logic               tid_valid;
      logic               rejected;
      logic               unlink_mid;
      logic [TASK_W-1:0]  tid;
      logic [TASK_W-1:0]  head1;
      logic [TASK_W-1:0]  tail1;
      logic [SIZE_W-1:0]  sz1;
      logic [TASK_W-1:0]  head_u;
      logic [TASK_W-1:0]  tail_u;
      logic [SIZE_W-1:0]  size_u;

      state_in   = state_ff;
      req_in     = req_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      size_in    = size_ff;
      running_in = running_ff;
      quantum_in = quantum_ff;
      mark_in    = mark_ff;
      done       = 1'b0;
      switched   = 1'b0;
      status     = 1'b0;
      link_wr    = '0;

      tid        = req_ff.task_id;
      q_dec      = (quantum_ff != '0) ? quantum_ff - 1'b1 : '0;
      run_valid  = ({1'b0, running_ff} < (TASK_W+1)'(NUM_TASKS));
      tid_valid  = ({1'b0, tid} < (TASK_W+1)'(NUM_TASKS));
      append_run = (running_ff != cfg.idle_task_id) && run_valid;
      rejected   = !tid_valid || (tid == running_ff) || (tid == cfg.idle_task_id);
      head1      = head_ff;
      tail1      = tail_ff;
      sz1        = size_ff;
      head_u     = head_ff;
      tail_u     = tail_ff;
      size_u     = size_ff;
      unlink_mid = 1'b0;

      // Read links for the head on a tick, for the named task on a move
      link_rd.re        = (state_ff == ST_IDLE) && start;
      link_rd.next_addr = (req.mode == MODE_TICK) ? head_ff : req.task_id;
      link_rd.prev_addr = req.task_id;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (rsp_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
               if (req_ff.mode == MODE_TICK) begin
                  quantum_in = q_dec;
                  if (q_dec == '0) begin
                     switched = 1'b1;
                     // Requeue the preempted task at the tail
                     if (append_run) begin
                        mark_in[running_ff] = MARK_READY;
                        if (size_ff == '0) begin
                           head1 = running_ff;
                        end else begin
                           link_wr.next_we   = 1'b1;
                           link_wr.next_addr = tail_ff;
                           link_wr.next_data = running_ff;
                           link_wr.prev_we   = 1'b1;
                           link_wr.prev_addr = running_ff;
                           link_wr.prev_data = tail_ff;
                        end
                        tail1 = running_ff;
                        sz1   = size_ff + 1'b1;
                     end
                     if (sz1 == '0) begin
                        running_in = cfg.idle_task_id;
                        quantum_in = '0;
                     end else begin
                        // Dispatch the head
                        if (sz1 == SIZE_W'(1)) begin
                           head_in = '0;
                           tail_in = '0;
                        end else begin
                           // Forward the link just written when head and tail coincide
                           if (append_run && (tail_ff == head_ff)) begin
                              head_in = running_ff;
                           end else begin
                              head_in = next_rd;
                           end
                           tail_in = tail1;
                        end
                        size_in        = sz1 - 1'b1;
                        mark_in[head1] = MARK_RUN;
                        running_in     = head1;
                        quantum_in     = cfg.quantum_length;
                     end
                  end
               end else begin
                  status = rejected;
                  if (!rejected) begin
                     // Unlink a queued task first
                     if ((mark_ff[tid] == MARK_READY) && (size_ff != '0)) begin
                        if (size_ff == SIZE_W'(1)) begin
                           head_u = '0;
                           tail_u = '0;
                        end else if (tid == head_ff) begin
                           head_u = next_rd;
                        end else if (tid == tail_ff) begin
                           tail_u = prev_rd;
                        end else begin
                           unlink_mid        = 1'b1;
                           link_wr.next_we   = 1'b1;
                           link_wr.next_addr = prev_rd;
                           link_wr.next_data = next_rd;
                           link_wr.prev_we   = 1'b1;
                           link_wr.prev_addr = next_rd;
                           link_wr.prev_data = prev_rd;
                        end
                        size_u = size_ff - 1'b1;
                     end
                     head_in = head_u;
                     tail_in = tail_u;
                     size_in = size_u;
                     case (req_ff.destination)
                        DEST_READY: begin
                           mark_in[tid] = MARK_READY;
                           if (unlink_mid) begin
                              // Link ports are taken; append next cycle
                              done     = 1'b0;
                              state_in = ST_APPEND;
                           end else begin
                              if (size_u == '0) begin
                                 head_in = tid;
                              end else begin
                                 link_wr.next_we   = 1'b1;
                                 link_wr.next_addr = tail_u;
                                 link_wr.next_data = tid;
                                 link_wr.prev_we   = 1'b1;
                                 link_wr.prev_addr = tid;
                                 link_wr.prev_data = tail_u;
                              end
                              tail_in = tid;
                              size_in = size_u + 1'b1;
                           end
                        end
                        DEST_FREE: begin
                           mark_in[tid] = MARK_FREE;
                        end
                        default: begin
                           mark_in[tid] = MARK_BLOCKED;
                        end
                     endcase
                  end
               end
            end
         end
         ST_APPEND: begin
            if (rsp_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
               if (size_ff == '0) begin
                  head_in = tid;
               end else begin
                  link_wr.next_we   = 1'b1;
                  link_wr.next_addr = tail_ff;
                  link_wr.next_data = tid;
                  link_wr.prev_we   = 1'b1;
                  link_wr.prev_addr = tid;
                  link_wr.prev_data = tail_ff;
               end
               tail_in = tid;
               size_in = size_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         head_ff    <= '0;
         tail_ff    <= '0;
         size_ff    <= '0;
         running_ff <= TASK_W'(1);
         quantum_ff <= '0;
         for (int i = 0; i < NUM_TASKS; i++) begin
            mark_ff[i] <= (i == 1) ? MARK_RUN : MARK_FREE;
         end
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         size_ff    <= size_in;
         running_ff <= running_in;
         quantum_ff <= quantum_in;
         mark_ff    <= mark_in;
      end
      req_ff <= req_in;
   end

   assign stat.busy           = (state_ff != ST_IDLE);
   assign stat.done           = done;
   assign result.running_task = running_in;
   assign result.switched     = switched;
   assign result.ready_count  = size_in;
   assign result.status       = status;

endmodule

// ===== hw/rtl/rrts_checker.sv =====
// Port-level checks for the round-robin task scheduler core, bound to the top level.
// Depends on rrts_pkg and round_robin_task_scheduler_core.
module rrts_checker import rrts_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous still in flight");

   a_switch_or_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.switched && rsp_data.status))
      else $error("response both switched and rejected");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.ready_count <= SIZE_W'(NUM_TASKS)))
      else $error("ready count beyond task count");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

endmodule

bind round_robin_task_scheduler_core rrts_checker u_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for round_robin_task_scheduler_core.
// Predicts each response from its ready-queue model or a directed row; compares it whole.
// Depends on rrts_pkg and the scheduler core RTL only.
module testbench;
   import rrts_pkg::*;

   // Destinations that the package leaves unnamed: both mean blocked
   localparam logic [1:0] DEST_BLOCKED = 2'd2;
   localparam logic [1:0] DEST_SPARE   = 2'd3;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int REPORT_CAP     = 200;

   // One directed row: the request, how many times to send it, and an optional
   // hand-written response where it is obvious at a glance.
   typedef struct packed {
      req_type    rq;
      logic [5:0] reps;
      logic       typed;
      rsp_type    want;
   } drill_row_type;

   // One random phase: optional register setting applied first, then random requests.
   typedef struct packed {
      logic       write;
      logic [7:0] quantum;
      logic [3:0] idle;
      logic       follow_run;   // make the idle task the task running right now
      logic [9:0] items;
      logic [6:0] tick_pct;
   } phase_plan_type;

   localparam drill_row_type DRILL [16] = '{
      // first tick after reset: task 1 requeued and dispatched again
      {MODE_TICK, 4'd0,  DEST_READY,   6'd1,  1'b1, 4'd1, 1'b1, 5'd0, 1'b0},
      // moves of the idle task and of the running task are rejected
      {MODE_MOVE, 4'd0,  DEST_READY,   6'd1,  1'b1, 4'd1, 1'b0, 5'd0, 1'b1},
      {MODE_MOVE, 4'd1,  DEST_BLOCKED, 6'd1,  1'b1, 4'd1, 1'b0, 5'd0, 1'b1},
      {MODE_MOVE, 4'd15, DEST_READY,   6'd1,  1'b1, 4'd1, 1'b0, 5'd1, 1'b0},
      // ready task moved to ready again
      {MODE_MOVE, 4'd15, DEST_READY,   6'd1,  1'b1, 4'd1, 1'b0, 5'd1, 1'b0},
      {MODE_MOVE, 4'd2,  DEST_READY,   6'd1,  1'b1, 4'd1, 1'b0, 5'd2, 1'b0},
      // destination 3 acts as blocked
      {MODE_MOVE, 4'd3,  DEST_SPARE,   6'd1,  1'b1, 4'd1, 1'b0, 5'd2, 1'b0},
      {MODE_MOVE, 4'd4,  DEST_READY,   6'd1,  1'b1, 4'd1, 1'b0, 5'd3, 1'b0},
      // interior of the queue: requeue, then free
      {MODE_MOVE, 4'd2,  DEST_READY,   6'd1,  1'b0, 4'd0, 1'b0, 5'd0, 1'b0},
      {MODE_MOVE, 4'd4,  DEST_FREE,    6'd1,  1'b0, 4'd0, 1'b0, 5'd0, 1'b0},
      {MODE_MOVE, 4'd3,  DEST_READY,   6'd1,  1'b0, 4'd0, 1'b0, 5'd0, 1'b0},
      // unlink at the head
      {MODE_MOVE, 4'd15, DEST_BLOCKED, 6'd1,  1'b0, 4'd0, 1'b0, 5'd0, 1'b0},
      // burn the whole quantum; ignored fields all ones
      {MODE_TICK, 4'd15, DEST_SPARE,   6'd10, 1'b0, 4'd0, 1'b0, 5'd0, 1'b0},
      // unlink at the tail, then the last queued task
      {MODE_MOVE, 4'd1,  DEST_FREE,    6'd1,  1'b0, 4'd0, 1'b0, 5'd0, 1'b0},
      {MODE_MOVE, 4'd3,  DEST_FREE,    6'd1,  1'b0, 4'd0, 1'b0, 5'd0, 1'b0},
      {MODE_MOVE, 4'd2,  DEST_READY,   6'd1,  1'b0, 4'd0, 1'b0, 5'd0, 1'b0}
   };

   localparam phase_plan_type PLAN [6] = '{
      {1'b0, 8'd10,  4'd0,  1'b0, 10'd300, 7'd40},
      {1'b1, 8'd1,   4'd15, 1'b0, 10'd300, 7'd40},
      {1'b1, 8'd255, 4'd3,  1'b0, 10'd200, 7'd70},
      {1'b1, 8'd0,   4'd7,  1'b0, 10'd300, 7'd40},
      {1'b1, 8'd3,   4'd0,  1'b1, 10'd300, 7'd45},
      {1'b1, 8'd2,   4'd0,  1'b0, 10'd300, 7'd35}
   };

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // Scheduler model state
   mark_type          task_state [NUM_TASKS];
   logic [TASK_W-1:0] link_next  [NUM_TASKS];
   logic [TASK_W-1:0] link_prev  [NUM_TASKS];
   logic [TASK_W-1:0] queue_head;
   logic [TASK_W-1:0] queue_tail;
   int                queue_len;
   logic [TASK_W-1:0] active_task;
   logic [QUANT_W-1:0] slice_left;
   logic [QUANT_W-1:0] slice_length;
   logic [TASK_W-1:0] idle_id;

   rsp_type due_outcomes [$];
   int      fault_count = 0;
   logic    rsp_take;
   logic    req_calm;
   logic    rsp_calm = 1'b0;
   int      hold_left;

   round_robin_task_scheduler_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Unlink a task from the ready queue. Links of the new head are left as they are.
   function automatic void queue_drop(logic [TASK_W-1:0] t);
      logic [TASK_W-1:0] p;
      logic [TASK_W-1:0] n;
      if (queue_len == 0) begin
         return;
      end
      if (queue_len == 1) begin
         queue_head = '0;
         queue_tail = '0;
      end else if (t == queue_head) begin
         queue_head = link_next[t];
      end else if (t == queue_tail) begin
         queue_tail = link_prev[t];
      end else begin
         p = link_prev[t];
         n = link_next[t];
         link_next[p] = n;
         link_prev[n] = p;
      end
      queue_len--;
   endfunction

   // Append a task at the tail of the ready queue.
   function automatic void queue_push_tail(logic [TASK_W-1:0] t);
      if (queue_len == 0) begin
         queue_head = t;
      end else begin
         link_next[queue_tail] = t;
         link_prev[t] = queue_tail;
      end
      queue_tail = t;
      queue_len++;
   endfunction

   // Advance the scheduler model by one request and return the response it owes.
   function automatic rsp_type dispatch_outcome(req_type r);
      rsp_type           o;
      logic [TASK_W-1:0] h;
      o = '0;
      if (r.mode == MODE_TICK) begin
         if (slice_left != 0) begin
            slice_left--;
         end
         if (slice_left == 0) begin
            o.switched = 1'b1;
            // the idle task is never queued
            if (active_task != idle_id) begin
               task_state[active_task] = MARK_READY;
               queue_push_tail(active_task);
            end
            if (queue_len == 0) begin
               active_task = idle_id;
               slice_left  = '0;
            end else begin
               h = queue_head;
               queue_drop(h);
               task_state[h] = MARK_RUN;
               active_task   = h;
               slice_left    = slice_length;
            end
         end
      end else if (r.task_id == active_task || r.task_id == idle_id) begin
         o.status = 1'b1;
      end else begin
         // only queued tasks carry the ready mark, so a stale run mark just changes
         if (task_state[r.task_id] == MARK_READY) begin
            queue_drop(r.task_id);
         end
         if (r.destination == DEST_READY) begin
            queue_push_tail(r.task_id);
            task_state[r.task_id] = MARK_READY;
         end else if (r.destination == DEST_FREE) begin
            task_state[r.task_id] = MARK_FREE;
         end else begin
            task_state[r.task_id] = MARK_BLOCKED;
         end
      end
      o.running_task = active_task;
      o.ready_count  = queue_len[SIZE_W-1:0];
      return o;
   endfunction

   // Send one request after a random gap; record its response at the falling edge that sees it taken.
   task automatic issue_request(req_type r, logic typed, rsp_type want);
      int      gap;
      logic    took;
      rsp_type owed;
      if ($urandom_range(0, 47) == 0) begin
         req_calm = ~req_calm;
      end
      gap = req_calm ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      took = 1'b0;
      while (!took) begin
         @(negedge clock);
         took = !req_stall;
         if (!took) begin
            @(posedge clock);
         end
      end
      owed = dispatch_outcome(r);
      due_outcomes.push_back(typed ? want : owed);
      @(posedge clock);
   endtask

   // Write one register; valid is left high so back-to-back writes need no dip.
   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      logic took;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      took = 1'b0;
      while (!took) begin
         @(negedge clock);
         took = csr_ready;
         @(posedge clock);
      end
      if (idx == CSR_QUANTUM) begin
         slice_length = value;
      end else begin
         idle_id = value[TASK_W-1:0];
      end
   endtask

   // Response checker: sample at the falling edge, where everything is settled.
   always @(negedge clock) begin
      rsp_take = !reset && rsp_valid && !rsp_stall;
      if (rsp_take) begin
         if (due_outcomes.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_CAP) begin
               $display("%0t: response with none pending: run=%0d sw=%0d cnt=%0d st=%0d",
                        $time, rsp_data.running_task, rsp_data.switched,
                        rsp_data.ready_count, rsp_data.status);
            end
         end else begin
            if (rsp_data !== due_outcomes[0]) begin
               fault_count++;
               if (fault_count <= REPORT_CAP) begin
                  $display("%0t: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                           $time, due_outcomes[0].running_task, due_outcomes[0].switched,
                           due_outcomes[0].ready_count, due_outcomes[0].status,
                           rsp_data.running_task, rsp_data.switched,
                           rsp_data.ready_count, rsp_data.status);
               end
            end
            void'(due_outcomes.pop_front());
         end
      end
   end

   // Response back-pressure: hold a random number of cycles after each taken response,
   // with calm stretches where the stall never rises.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_take) begin
            if ($urandom_range(0, 47) == 0) begin
               rsp_calm = ~rsp_calm;
            end
            hold_left = rsp_calm ? 0 : $urandom_range(0, 16);
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: give up when no channel moves for too long.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(negedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("Verification failed");
      $finish;
   end

   initial begin
      int      i;
      int      k;
      int      n;
      req_type rq;
      rsp_type nothing;

      req_calm    = 1'b0;
      nothing     = '0;
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_data   <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;

      // Model state after reset: task 1 running, everything else free
      for (i = 0; i < NUM_TASKS; i++) begin
         task_state[i] = MARK_FREE;
         link_next[i]  = '0;
         link_prev[i]  = '0;
      end
      task_state[1] = MARK_RUN;
      queue_head    = '0;
      queue_tail    = '0;
      queue_len     = 0;
      active_task   = 4'd1;
      slice_left    = '0;
      slice_length  = 8'd10;
      idle_id       = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows
      for (i = 0; i < 16; i++) begin
         for (k = 0; k < DRILL[i].reps; k++) begin
            issue_request(DRILL[i].rq, DRILL[i].typed, DRILL[i].want);
         end
      end

      // Random phases, each under its own register setting
      for (i = 0; i < 6; i++) begin
         if (PLAN[i].write) begin
            // drain, let the link write-back finish, then reprogram
            req_valid <= 1'b0;
            while (due_outcomes.size() != 0) @(posedge clock);
            repeat (SETTLE_CYCLES) @(posedge clock);
            write_register(CSR_QUANTUM, PLAN[i].quantum);
            write_register(CSR_IDLE, {4'($urandom_range(0, 15)),
                           PLAN[i].follow_run ? active_task : PLAN[i].idle});
            csr_valid <= 1'b0;
         end
         for (n = 0; n < PLAN[i].items; n++) begin
            rq.task_id = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 99) < PLAN[i].tick_pct) begin
               rq.mode        = MODE_TICK;
               rq.destination = 2'($urandom_range(0, 3));
            end else begin
               rq.mode = MODE_MOVE;
               // favor ready so the queue grows long
               case ($urandom_range(0, 5))
                  0, 1, 2: rq.destination = DEST_READY;
                  3:       rq.destination = DEST_FREE;
                  4:       rq.destination = DEST_BLOCKED;
                  default: rq.destination = DEST_SPARE;
               endcase
            end
            issue_request(rq, 1'b0, nothing);
         end
      end

      req_valid <= 1'b0;
      while (due_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/rrts_pkg.sv
hw/rtl/rrts_link_mem.sv
hw/rtl/rrts_engine.sv
hw/rtl/round_robin_task_scheduler_core.sv
hw/rtl/rrts_checker.sv
tb/testbench.sv
